// ----- hw/rtl/vtd_pkg.sv -----
// ----------------------------------------------------------------------------
// vtd_pkg
// Shared constants and types for the vertex transform and divide core.
// ----------------------------------------------------------------------------
package vtd_pkg;

    localparam int CW      = 32;
    localparam int FB      = 16;
    localparam int NREGS   = 8;
    localparam int IDX_W   = 8;
    localparam int REG_W   = 64;
    localparam int PW      = 2 * CW;
    localparam int SW      = PW + 2;
    localparam int QW      = CW + FB;
    localparam int BPS     = 4;
    localparam int NDS     = (QW + BPS - 1) / BPS;
    localparam int NW      = NDS * BPS;

    localparam logic [REG_W-1:0] REG_RESET [NREGS] = '{
        64'd65536, 64'd0, 64'd281474976710656, 64'd0,
        64'd0, 64'd65536, 64'd0, 64'd281474976710656
    };

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        logic [2:0][CW-1:0] v;
        logic [2:0]         neg;
        logic               divided;
        logic               sat;
    } meta_t;

    typedef struct packed {
        logic [CW-1:0] rem;
        logic [NW-1:0] num;
        logic [NW-1:0] quo;
    } div_t;

endpackage

// ----- hw/rtl/vtd_if.sv -----
// ----------------------------------------------------------------------------
// vtd interfaces
// Point, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vtd_point_if;
    logic                    valid;
    logic                    ready;
    logic signed [31:0]      point_x;
    logic signed [31:0]      point_y;
    logic signed [31:0]      point_z;
    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface vtd_result_if;
    logic                    valid;
    logic                    ready;
    logic signed [31:0]      out_x;
    logic signed [31:0]      out_y;
    logic signed [31:0]      out_z;
    logic                    was_divided;
    logic                    saturated;
    modport source (output valid, out_x, out_y, out_z, was_divided, saturated, input ready);
    modport sink (input valid, out_x, out_y, out_z, was_divided, saturated, output ready);
endinterface

interface vtd_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/vertex_transform_divide_core.sv -----
// ----------------------------------------------------------------------------
// vertex_transform_divide_core
// 4x4 matrix transform of (x,y,z,1) with perspective divide by w unless w is 0 or 1.0, Q15.16.
// ----------------------------------------------------------------------------
// Channels: pt (sink) takes one point per transaction, res (source) gives one
// result per point, cfg (sink) writes the eight 64-bit matrix registers;
// cfg is always ready, and an index beyond 7 is dropped. Write only when
// the pipeline is empty.
// Throughput: one point per cycle while res is not stalled. Stages from acceptance
// to res.valid: multiply, sum, clamp, divide setup, 12 divider stages of four
// quotient bits each, and the output register.
// The whole pipeline advances when the output register is empty or taken;
// while res is stalled with a result waiting, pt.ready is low and every
// stage holds.
// Reset clears all valid bits and loads REG_RESET into the matrix registers.
// ----------------------------------------------------------------------------
module vertex_transform_divide_core
(
    input  logic            clk,
    input  logic            rst_n,
    vtd_point_if.sink       pt,
    vtd_result_if.source    res,
    vtd_cfg_if.sink         cfg
);

    localparam int CW  = vtd_pkg::CW;
    localparam int FB  = vtd_pkg::FB;
    localparam int PW  = vtd_pkg::PW;
    localparam int SW  = vtd_pkg::SW;
    localparam int NW  = vtd_pkg::NW;
    localparam int NDS = vtd_pkg::NDS;
    localparam int BPS = vtd_pkg::BPS;

    logic [vtd_pkg::REG_W-1:0] mat_reg [vtd_pkg::NREGS];
    logic adv;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < vtd_pkg::NREGS; i++)
                mat_reg[i] <= vtd_pkg::REG_RESET[i];
        end
        else if (cfg.valid && (cfg.index < vtd_pkg::IDX_W'(vtd_pkg::NREGS)))
        begin
            mat_reg[cfg.index[2:0]] <= cfg.data;
        end
    end

    function automatic logic signed [CW-1:0] coef(input int c, input int r);
        logic [vtd_pkg::REG_W-1:0] w;
        w = mat_reg[c * 2 + r / 2];
        return (r % 2 == 1) ? w[32 +: CW] : w[0 +: CW];
    endfunction

    // stage 1: products
    logic signed [CW-1:0] p [3];
    logic signed [PW-1:0] prod_reg [4][3];
    logic signed [CW-1:0] tr_reg [4];
    logic                 v1_reg;

    assign p[0] = pt.point_x[CW-1:0];
    assign p[1] = pt.point_y[CW-1:0];
    assign p[2] = pt.point_z[CW-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 3; c++)
                    prod_reg[r][c] <= coef(c, r) * p[c];
                tr_reg[r] <= coef(3, r);
            end
        end
    end

    // stage 2: exact sums
    logic signed [SW-1:0] sum_reg [4];
    logic                 v2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 4; r++)
                sum_reg[r] <= SW'(prod_reg[r][0]) + SW'(prod_reg[r][1]) + SW'(prod_reg[r][2])
                              + (SW'(tr_reg[r]) <<< FB);
        end
    end

    // stage 3: truncate toward zero and clamp
    logic [SW-1:0]        mag [4];
    logic signed [CW-1:0] rv [4];
    logic [3:0]           rsat;
    logic signed [CW-1:0] row_reg [4];
    logic                 sat3_reg;
    logic                 v3_reg;

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            mag[r] = (sum_reg[r] < 0) ? (SW'(0) - SW'(sum_reg[r])) >> FB : SW'(sum_reg[r]) >> FB;
            rsat[r] = 1'b0;
            if (sum_reg[r] < 0)
            begin
                if (mag[r] > (SW'(1) << (CW - 1)))
                begin
                    rsat[r] = 1'b1;
                    rv[r] = {1'b1, {(CW-1){1'b0}}};
                end
                else
                    rv[r] = CW'(SW'(0) - mag[r]);
            end
            else
            begin
                if (mag[r] > ((SW'(1) << (CW - 1)) - SW'(1)))
                begin
                    rsat[r] = 1'b1;
                    rv[r] = {1'b0, {(CW-1){1'b1}}};
                end
                else
                    rv[r] = CW'(mag[r]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 4; r++)
                row_reg[r] <= rv[r];
            sat3_reg <= |rsat;
        end
    end

    function automatic vtd_pkg::div_t dstep(input vtd_pkg::div_t s, input logic [CW-1:0] d);
        vtd_pkg::div_t o;
        logic [CW:0]   r;
        o = s;
        for (int i = 0; i < BPS; i++)
        begin
            r = {o.rem, o.num[NW-1]};
            o.num = o.num << 1;
            if (r >= {1'b0, d})
            begin
                r = r - {1'b0, d};
                o.quo = {o.quo[NW-2:0], 1'b1};
            end
            else
                o.quo = {o.quo[NW-2:0], 1'b0};
            o.rem = r[CW-1:0];
        end
        return o;
    endfunction

    // stage 4: divide setup, then divider stages
    vtd_pkg::meta_t       meta_reg [NDS+1];
    vtd_pkg::div_t        dv_reg [NDS+1][3];
    logic [CW-1:0]        dsr_reg [NDS+1];
    logic [NDS:0]         vd_reg;
    logic [CW-1:0]        wmag;
    logic                 wneg;

    assign wneg = row_reg[3] < 0;
    assign wmag = wneg ? CW'(0) - CW'(row_reg[3]) : CW'(row_reg[3]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            meta_reg[0].sat     <= sat3_reg;
            meta_reg[0].divided <= (row_reg[3] != '0) && (row_reg[3] != (CW'(1) << FB));
            dsr_reg[0]          <= wmag;
            for (int l = 0; l < 3; l++)
            begin
                meta_reg[0].v[l]   <= row_reg[l];
                meta_reg[0].neg[l] <= (row_reg[l] < 0) != wneg;
                dv_reg[0][l].rem   <= '0;
                dv_reg[0][l].quo   <= '0;
                dv_reg[0][l].num   <= NW'((row_reg[l] < 0) ? CW'(0) - CW'(row_reg[l])
                                                           : CW'(row_reg[l])) << FB;
            end
            for (int k = 0; k < NDS; k++)
            begin
                meta_reg[k+1] <= meta_reg[k];
                dsr_reg[k+1]  <= dsr_reg[k];
                for (int l = 0; l < 3; l++)
                    dv_reg[k+1][l] <= dstep(dv_reg[k][l], dsr_reg[k]);
            end
        end
    end

    // output stage: clamp quotients, then select them or the undivided values
    logic [2:0][CW-1:0] q_out;
    logic [2:0]         qsat;
    logic               out_valid_reg;
    logic [2:0][CW-1:0] out_v_reg;
    logic               out_div_reg;
    logic               out_sat_reg;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            qsat[l] = 1'b0;
            if (meta_reg[NDS].neg[l])
            begin
                if (dv_reg[NDS][l].quo > (NW'(1) << (CW - 1)))
                begin
                    qsat[l] = 1'b1;
                    q_out[l] = {1'b1, {(CW-1){1'b0}}};
                end
                else
                    q_out[l] = CW'(NW'(0) - dv_reg[NDS][l].quo);
            end
            else
            begin
                if (dv_reg[NDS][l].quo > ((NW'(1) << (CW - 1)) - NW'(1)))
                begin
                    qsat[l] = 1'b1;
                    q_out[l] = {1'b0, {(CW-1){1'b1}}};
                end
                else
                    q_out[l] = CW'(dv_reg[NDS][l].quo);
            end
        end
    end

    assign adv = !out_valid_reg || res.ready;
    assign pt.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            vd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= pt.valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            vd_reg        <= {vd_reg[NDS-1:0], v3_reg};
            out_valid_reg <= vd_reg[NDS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_div_reg <= meta_reg[NDS].divided;
            out_sat_reg <= meta_reg[NDS].sat || (meta_reg[NDS].divided && (|qsat));
            out_v_reg   <= meta_reg[NDS].divided ? q_out : meta_reg[NDS].v;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.out_x       = 32'(signed'(out_v_reg[0]));
    assign res.out_y       = 32'(signed'(out_v_reg[1]));
    assign res.out_z       = 32'(signed'(out_v_reg[2]));
    assign res.was_divided = out_div_reg;
    assign res.saturated   = out_sat_reg;

endmodule

// ----- hw/rtl/vtd_checker.sv -----
// ----------------------------------------------------------------------------
// vtd_checker
// Port-level checks for vertex_transform_divide_core.
// ----------------------------------------------------------------------------
module vtd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_x,
    input logic        cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x))
        else $error("result dropped while stalled");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    a_free_runs: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result present after reset");

endmodule

bind vertex_transform_divide_core vtd_checker u_vtd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (pt.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_x     (res.out_x),
    .cfg_ready (cfg.ready)
);
